>>> rtl/smaa_pkg.sv
`timescale 1ns / 1ps

package smaa_pkg;

  // Default stack depth.
  localparam int DEPTH_DEF = 64;

  // Fixed field widths.
  localparam int VAL_W  = 32;
  localparam int AVG_W  = 40;
  localparam int FRAC_W = 8;

  // Top value reported while the stack is empty.
  localparam logic [VAL_W-1:0] TOP_EMPTY = {VAL_W{1'b1}};

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Status of the divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/smaa_if.sv
`timescale 1ns / 1ps

interface smaa_req_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic signed [smaa_pkg::VAL_W-1:0]      push_value;

  modport source (output valid, kind, push_value, input ready);
  modport sink   (input valid, kind, push_value, output ready);
endinterface

interface smaa_rsp_if #(
  parameter int CNT_W = 7
);
  logic                                   valid;
  logic                                   ready;
  logic signed [smaa_pkg::VAL_W-1:0]      top_value;
  logic                                   is_empty;
  logic [CNT_W-1:0]                       entry_count;
  logic signed [smaa_pkg::VAL_W-1:0]      max_value;
  logic signed [smaa_pkg::AVG_W-1:0]      average_q8;
  logic [1:0]                             status;

  modport source (output valid, top_value, is_empty, entry_count, max_value, average_q8,
                  status, input ready);
  modport sink   (input valid, top_value, is_empty, entry_count, max_value, average_q8,
                  status, output ready);
endinterface

>>> rtl/stack_with_max_and_average.sv
`timescale 1ns / 1ps

// LIFO stack of signed 32-bit values that reports, after every push or pop transaction,
// the top value (-1 when empty), the entry count, the largest stored value (0 when empty)
// and the mean in signed fixed point with 8 fraction bits, truncated toward zero (0 when
// empty). A push onto a full stack is dropped with status 1; a pop on an empty stack is
// ignored with status 2. One transaction is handled at a time: the request channel is
// ready only while the sequencer is idle. For a transaction with a nonempty result, the
// restoring divider forms the mean one quotient bit per cycle; a pop that leaves at least
// one entry first passes through a state that reads the RAM. On an empty result the
// divider is skipped. The value and running-maximum stacks share one RAM with a registered
// read; the current top entry is also held in flops, so only a pop costs a RAM read. A
// finished result sits in an output register and waits there for the consumer, which adds
// the cycles the consumer stalls.
module stack_with_max_and_average #(
  parameter int DEPTH = smaa_pkg::DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smaa_req_if.sink   req_i,
  smaa_rsp_if.source rsp_o
);
  import smaa_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = VAL_W + $clog2(DEPTH);
  localparam int DVD_W  = SUM_W + FRAC_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_READ  = 7'b0000100,
    S_START = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [SUM_W-1:0]  sum_q;
  logic [VAL_W-1:0]  top_q, topmax_q;
  kind_e             kind_q;
  logic [VAL_W-1:0]  val_q;
  status_e           status_q;
  logic [AVG_W-1:0]  avg_q;

  logic              out_valid_q;
  logic [VAL_W-1:0]  out_top_q, out_max_q;
  logic              out_empty_q;
  logic [CNT_W-1:0]  out_count_q;
  logic [AVG_W-1:0]  out_avg_q;
  status_e           out_status_q;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [2*VAL_W-1:0] ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  count_m2;

  logic              div_start;
  div_stat_t         div_stat;
  logic [DVD_W-1:0]  div_quot;
  logic [SUM_W-1:0]  sum_abs;
  logic [AVG_W-1:0]  quot_lo;

  logic              is_full;
  logic              new_gt;
  logic [VAL_W-1:0]  new_max;
  logic              out_load;

  assign is_full   = count_q == CNT_W'(DEPTH);
  assign new_gt    = $signed(val_q) > $signed(topmax_q);
  assign new_max   = (count_q == '0 || new_gt) ? val_q : topmax_q;
  assign count_m2  = count_q - CNT_W'(2);

  assign ram_we    = state_q == S_EXEC && kind_q == KIND_PUSH && !is_full;
  assign ram_waddr = count_q[ADDR_W-1:0];
  assign ram_wdata = {new_max, val_q};
  assign ram_re    = state_q == S_EXEC && kind_q == KIND_POP && count_q > CNT_W'(1);
  assign ram_raddr = count_m2[ADDR_W-1:0];

  assign sum_abs   = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
  assign div_start = state_q == S_START && count_q != '0;
  assign quot_lo   = div_quot[AVG_W-1:0];
  assign out_load  = state_q == S_DONE && (!out_valid_q || rsp_o.ready);

  smaa_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  smaa_div #(
    .DVD_W (DVD_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_abs, {FRAC_W{1'b0}}}),
    .divisor_i  (count_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (ram_re) begin
          state_d = S_READ;
        end else begin
          state_d = S_START;
        end
      end
      S_READ:  state_d = S_START;
      S_START: begin
        if (count_q != '0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (div_stat.done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      S_WAIT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign req_i.ready = state_q == S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_EXEC) begin
        if (kind_q == KIND_PUSH && !is_full) begin
          count_q <= count_q + CNT_W'(1);
          sum_q   <= sum_q + {{(SUM_W-VAL_W){val_q[VAL_W-1]}}, val_q};
        end else if (kind_q == KIND_POP && count_q != '0) begin
          count_q <= count_q - CNT_W'(1);
          sum_q   <= sum_q - {{(SUM_W-VAL_W){top_q[VAL_W-1]}}, top_q};
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      kind_q <= kind_e'(req_i.kind);
      val_q  <= req_i.push_value;
    end
    if (state_q == S_EXEC) begin
      if (kind_q == KIND_PUSH && is_full) begin
        status_q <= ST_FULL;
      end else if (kind_q == KIND_POP && count_q == '0) begin
        status_q <= ST_EMPTY;
      end else begin
        status_q <= ST_DONE;
      end
      if (kind_q == KIND_PUSH && !is_full) begin
        top_q    <= val_q;
        topmax_q <= new_max;
      end
    end
    if (state_q == S_READ) begin
      top_q    <= ram_rdata[VAL_W-1:0];
      topmax_q <= ram_rdata[2*VAL_W-1:VAL_W];
    end
    if (state_q == S_START) begin
      avg_q <= '0;
    end
    if (div_stat.done) begin
      avg_q <= sum_q[SUM_W-1] ? (~quot_lo + AVG_W'(1)) : quot_lo;
    end
    if (out_load) begin
      out_top_q    <= (count_q == '0) ? TOP_EMPTY : top_q;
      out_max_q    <= (count_q == '0) ? '0 : topmax_q;
      out_empty_q  <= count_q == '0;
      out_count_q  <= count_q;
      out_avg_q    <= avg_q;
      out_status_q <= status_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.top_value   = out_top_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.max_value   = out_max_q;
  assign rsp_o.average_q8  = out_avg_q;
  assign rsp_o.status      = out_status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  // The mean is only divided out for a nonempty stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> count_q != '0)
    else $error("divider started on an empty stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> (out_empty_q == (out_count_q == '0)))
    else $error("empty flag disagrees with entry count");

  // A new transaction is only taken once the previous one has produced its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (req_i.valid && req_i.ready) |-> $past(state_q) == S_DONE ||
                   $past(state_q) == S_IDLE || $past(state_q) == S_WAIT)
    else $error("transaction accepted while sequencer busy");

endmodule

>>> rtl/smaa_ram.sv
`timescale 1ns / 1ps

module smaa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/smaa_div.sv
`timescale 1ns / 1ps

// Unsigned restoring divider, one quotient bit per cycle.
module smaa_div #(
  parameter int DVD_W = 46,
  parameter int DVS_W = 7
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DVD_W-1:0]        dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output smaa_pkg::div_stat_t     stat_o,
  output logic [DVD_W-1:0]        quot_o
);
  import smaa_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    rem_d   = ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    dvd_d   = {dvd_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && !start_i && (step_q == STEP_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DVD_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;

  // The sequencer must not restart the unit while it is iterating.
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");

  // A restoring step keeps the partial remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (busy_q && !$rose(busy_q)) |-> rem_q < dvs_q)
    else $error("partial remainder not below divisor");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a preceding run");

endmodule
